// ----- design/fletcher16_frame_checker_defines.svh -----
// Assertion macros used by the frame checker top-level design file.
`ifndef FLETCHER16_FRAME_CHECKER_DEFINES_SVH
`define FLETCHER16_FRAME_CHECKER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define F16FC_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define F16FC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/f16fc_pkg.sv -----
// Types and constants of the Fletcher-16 frame checker.
package f16fc_pkg;

  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned POS_W = 9;

  typedef enum logic [1:0] {
    ROLE_HEADER  = 2'd0,
    ROLE_PAYLOAD = 2'd1,
    ROLE_CHECK   = 2'd2,
    ROLE_OUTSIDE = 2'd3
  } role_t;

  typedef struct packed {
    logic [7:0] out_byte;
    role_t      byte_role;
    logic       frame_done;
    logic       frame_ok;
    logic       is_ack;
    logic [7:0] frame_id;
    logic [7:0] acked_id;
    logic [7:0] payload_len;
  } result_t;

endpackage

// ----- design/f16fc_in_if.sv -----
// Input channel: one received byte per item with its frame start flag.
interface f16fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ----- design/f16fc_out_if.sv -----
// Output channel: the echoed byte, its role and the frame status.
interface f16fc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] byte_role;
  logic       frame_done;
  logic       frame_ok;
  logic       is_ack;
  logic [7:0] frame_id;
  logic [7:0] acked_id;
  logic [7:0] payload_len;

  modport source (
    output valid, output out_byte, output byte_role, output frame_done,
    output frame_ok, output is_ack, output frame_id, output acked_id,
    output payload_len, input ready
  );
  modport sink (
    input valid, input out_byte, input byte_role, input frame_done,
    input frame_ok, input is_ack, input frame_id, input acked_id,
    input payload_len, output ready
  );
endinterface

// ----- design/f16fc_parse.sv -----
// Frame parser: header capture, running Fletcher sums and check byte compare.
module f16fc_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic [7:0]           data_byte,
  input  logic                 frame_start,
  output f16fc_pkg::result_t   res
);

  localparam logic [f16fc_pkg::POS_W-1:0] HDR = f16fc_pkg::POS_W'(f16fc_pkg::HDR_BYTES);

  logic [f16fc_pkg::POS_W-1:0] byte_pos, byte_pos_next;
  logic                        in_frame, in_frame_next;
  logic [7:0]                  held_frame_id, held_frame_id_next;
  logic [7:0]                  held_ack_id, held_ack_id_next;
  logic [7:0]                  held_length, held_length_next;
  logic [7:0]                  running_sum1, running_sum1_next;
  logic [7:0]                  running_sum2, running_sum2_next;
  logic                        first_check_ok, first_check_ok_next;

  logic [f16fc_pkg::POS_W-1:0] pos;
  logic [f16fc_pkg::POS_W-1:0] body_end;
  logic [7:0]                  sum1_base, sum2_base, sum1_add, sum2_add;
  logic                        active, fco_base;

  // Adds two values below 256 and reduces mod 255; the sum is at most twice 255.
  function automatic logic [7:0] add_mod255(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= 9'd255) begin
      s = s - 9'd255;
    end
    return s[7:0];
  endfunction

  always_comb begin
    // A start flag drops whatever frame was in progress.
    active     = frame_start | in_frame;
    pos        = frame_start ? '0 : byte_pos;
    sum1_base  = frame_start ? 8'd0 : running_sum1;
    sum2_base  = frame_start ? 8'd0 : running_sum2;
    fco_base   = frame_start ? 1'b0 : first_check_ok;

    held_frame_id_next  = held_frame_id;
    held_ack_id_next    = frame_start ? 8'd0 : held_ack_id;
    held_length_next    = frame_start ? 8'd0 : held_length;
    running_sum1_next   = sum1_base;
    running_sum2_next   = sum2_base;
    first_check_ok_next = fco_base;
    in_frame_next       = active;
    byte_pos_next       = pos;

    body_end = HDR + {1'b0, held_length_next};
    sum1_add = add_mod255(sum1_base, data_byte);
    sum2_add = add_mod255(sum2_base, sum1_add);

    res.out_byte   = data_byte;
    res.byte_role  = f16fc_pkg::ROLE_OUTSIDE;
    res.frame_done = 1'b0;
    res.frame_ok   = 1'b0;
    res.is_ack     = 1'b0;

    if (active) begin
      if (pos < HDR) begin
        res.byte_role = f16fc_pkg::ROLE_HEADER;
        case (pos[1:0])
          2'd0:    held_frame_id_next = data_byte;
          2'd1:    held_ack_id_next   = data_byte;
          default: held_length_next   = data_byte;
        endcase
        running_sum1_next = sum1_add;
        running_sum2_next = sum2_add;
        byte_pos_next     = pos + 1'b1;
      end else if (pos < body_end) begin
        res.byte_role     = f16fc_pkg::ROLE_PAYLOAD;
        running_sum1_next = sum1_add;
        running_sum2_next = sum2_add;
        byte_pos_next     = pos + 1'b1;
      end else if (pos == body_end) begin
        res.byte_role       = f16fc_pkg::ROLE_CHECK;
        first_check_ok_next = (data_byte == sum1_base);
        byte_pos_next       = pos + 1'b1;
      end else begin
        res.byte_role  = f16fc_pkg::ROLE_CHECK;
        res.frame_done = 1'b1;
        res.frame_ok   = (held_frame_id_next != 8'd0) && fco_base && (data_byte == sum2_base);
        res.is_ack     = (held_ack_id_next != 8'd0);
        in_frame_next  = 1'b0;
        byte_pos_next  = '0;
      end
    end

    res.frame_id    = held_frame_id_next;
    res.acked_id    = held_ack_id_next;
    res.payload_len = held_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_pos       <= '0;
      in_frame       <= 1'b0;
      held_frame_id  <= 8'd0;
      held_ack_id    <= 8'd0;
      held_length    <= 8'd0;
      running_sum1   <= 8'd0;
      running_sum2   <= 8'd0;
      first_check_ok <= 1'b0;
    end else if (step) begin
      byte_pos       <= byte_pos_next;
      in_frame       <= in_frame_next;
      held_frame_id  <= held_frame_id_next;
      held_ack_id    <= held_ack_id_next;
      held_length    <= held_length_next;
      running_sum1   <= running_sum1_next;
      running_sum2   <= running_sum2_next;
      first_check_ok <= first_check_ok_next;
    end
  end

endmodule

// ----- design/fletcher16_frame_checker.sv -----
// Fletcher-16 frame checker: input register, frame parser and result register.
//
// The in_ch channel carries one received byte per item with a frame_start
// flag that marks the first byte of a frame. The out_ch channel returns
// exactly one item per input item: the byte echoed, its role in the frame,
// the header fields so far, and on the second check byte the frame status.
// An accepted item waits in the input register; the parser then updates its
// sums and header state as the item moves on into the result register. One
// item is taken per cycle unless a receiver stall has filled both registers,
// and the mod-255 sum update is combinational.
// When the receiver stalls, the result register holds its item and the
// input register keeps one more, so ready on in_ch drops only while both
// are full. A synchronous reset empties both registers and clears all
// parser state, so the first byte after reset is outside any frame unless
// it carries frame_start.
`include "fletcher16_frame_checker_defines.svh"

module fletcher16_frame_checker (
  input  logic         clk,
  input  logic         rst,
  f16fc_in_if.sink     in_ch,
  f16fc_out_if.source  out_ch
);

  logic                in_valid;
  logic [7:0]          in_byte;
  logic                in_start;
  logic                out_valid;
  logic                advance;
  f16fc_pkg::result_t  res;
  f16fc_pkg::result_t  res_q;

  assign advance     = !out_valid || out_ch.ready;
  assign in_ch.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte  <= in_ch.data_byte;
      in_start <= in_ch.frame_start;
    end
  end

  f16fc_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .step        (in_valid && advance),
    .data_byte   (in_byte),
    .frame_start (in_start),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && advance) begin
      res_q <= res;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.out_byte    = res_q.out_byte;
  assign out_ch.byte_role   = res_q.byte_role;
  assign out_ch.frame_done  = res_q.frame_done;
  assign out_ch.frame_ok    = res_q.frame_ok;
  assign out_ch.is_ack      = res_q.is_ack;
  assign out_ch.frame_id    = res_q.frame_id;
  assign out_ch.acked_id    = res_q.acked_id;
  assign out_ch.payload_len = res_q.payload_len;

  `F16FC_ASSERT_IMPLY(a_done_on_check, clk, rst, out_ch.valid && out_ch.frame_done, out_ch.byte_role == f16fc_pkg::ROLE_CHECK, "frame_done on a byte that is not a check byte")
  `F16FC_ASSERT_IMPLY(a_ok_needs_done, clk, rst, out_ch.valid && out_ch.frame_ok, out_ch.frame_done && out_ch.frame_id != 8'd0, "frame_ok without a completed frame with nonzero id")
  `F16FC_ASSERT_IMPLY(a_ack_flag, clk, rst, out_ch.valid, out_ch.is_ack == (out_ch.frame_done && out_ch.acked_id != 8'd0), "is_ack does not follow the ack id")
  `F16FC_ASSERT_IMPLY(a_stall_only_full, clk, rst, !in_ch.ready, in_valid && out_ch.valid && !out_ch.ready, "input stalled while a register is free")
  `F16FC_ASSERT_NEXT(a_result_follows, clk, rst, in_valid && advance, out_ch.valid, "parsed item did not reach the result register")

endmodule

// ----- tb/tb_fletcher16_frame_checker.sv -----
// Self-checking testbench for the Fletcher-16 frame checker.
module tb_fletcher16_frame_checker;

  localparam int QUIET_LIMIT = 1000;
  localparam int HOLD_CYCLES = 48;
  localparam int ITEM_GOAL = 1700;
  localparam int CALM_FROM = 1450;

  typedef enum int {CLEAN, BAD_SUM1, BAD_SUM2, CUT_SHORT} frame_flaw_t;

  // Tracks the deframer state and holds the echo expected for every accepted byte.
  class frame_result_book;
    f16fc_pkg::result_t pending[$];
    int unsigned        mismatches;
    logic [8:0]         pos;
    logic               in_frame;
    logic [7:0]         fid, aid, len;
    logic [7:0]         s1, s2;
    logic               chk1_ok;

    function new();
      mismatches = 0;
      pos = '0;
      in_frame = 1'b0;
      fid = '0;
      aid = '0;
      len = '0;
      s1 = '0;
      s2 = '0;
      chk1_ok = 1'b0;
    endfunction

    function void note_byte(logic [7:0] b, logic st);
      f16fc_pkg::result_t r;
      int body_end;
      if (st) begin
        in_frame = 1'b1;
        pos = '0;
        s1 = '0;
        s2 = '0;
        chk1_ok = 1'b0;
        aid = '0;
        len = '0;
      end
      r = '0;
      r.out_byte = b;
      r.byte_role = f16fc_pkg::ROLE_OUTSIDE;
      if (in_frame) begin
        body_end = f16fc_pkg::HDR_BYTES + len;
        if (pos < body_end) begin
          if (pos < f16fc_pkg::HDR_BYTES) begin
            r.byte_role = f16fc_pkg::ROLE_HEADER;
            case (pos)
              9'd0: fid = b;
              9'd1: aid = b;
              default: len = b;
            endcase
          end else begin
            r.byte_role = f16fc_pkg::ROLE_PAYLOAD;
          end
          s1 = 8'((int'(s1) + int'(b)) % 255);
          s2 = 8'((int'(s2) + int'(s1)) % 255);
          pos = pos + 1'b1;
        end else if (pos == body_end) begin
          r.byte_role = f16fc_pkg::ROLE_CHECK;
          chk1_ok = (b == s1);
          pos = pos + 1'b1;
        end else begin
          r.byte_role = f16fc_pkg::ROLE_CHECK;
          r.frame_done = 1'b1;
          r.frame_ok = (fid != 0) && chk1_ok && (b == s2);
          r.is_ack = (aid != 0);
          in_frame = 1'b0;
          pos = '0;
        end
      end
      r.frame_id = fid;
      r.acked_id = aid;
      r.payload_len = len;
      pending.push_back(r);
    endfunction

    function void check_echo(f16fc_pkg::result_t got);
      f16fc_pkg::result_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: byte=%h role=%0d", got.out_byte, got.byte_role);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: want byte=%h role=%0d done=%b ok=%b ack=%b id=%h ackid=%h len=%h",
                   want.out_byte, want.byte_role, want.frame_done, want.frame_ok,
                   want.is_ack, want.frame_id, want.acked_id, want.payload_len);
          $display("           got byte=%h role=%0d done=%b ok=%b ack=%b id=%h ackid=%h len=%h",
                   got.out_byte, got.byte_role, got.frame_done, got.frame_ok,
                   got.is_ack, got.frame_id, got.acked_id, got.payload_len);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  f16fc_in_if  in_ch ();
  f16fc_out_if out_ch ();

  fletcher16_frame_checker dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  frame_result_book   book;
  f16fc_pkg::result_t seen;
  int                 bytes_sent = 0;
  bit                 gaps_on = 1'b1;
  bit                 stalls_on = 1'b1;
  bit                 calm = 1'b0;
  bit                 long_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    if (gaps_on && !calm && !long_hold && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.frame_start <= st;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    book.note_byte(b, st);
    bytes_sent++;
  endtask

  // Builds a frame with its Fletcher-16 check bytes; a flaw spoils a check byte
  // or cuts the frame short so that the next start lands mid-frame.
  task automatic send_frame(input logic [7:0] fid, input logic [7:0] aid,
                            input logic [7:0] len, input frame_flaw_t flaw);
    logic [7:0] bytes[$];
    logic [7:0] s1, s2;
    int cut;
    bytes = {fid, aid, len};
    for (int i = 0; i < len; i++) bytes.push_back(8'($urandom));
    s1 = '0;
    s2 = '0;
    foreach (bytes[i]) begin
      s1 = 8'((int'(s1) + int'(bytes[i])) % 255);
      s2 = 8'((int'(s2) + int'(s1)) % 255);
    end
    if (flaw == BAD_SUM1) s1 = s1 ^ 8'($urandom_range(1, 255));
    if (flaw == BAD_SUM2) s2 = s2 ^ 8'($urandom_range(1, 255));
    bytes.push_back(s1);
    bytes.push_back(s2);
    cut = bytes.size();
    if (flaw == CUT_SHORT) cut = $urandom_range(1, bytes.size() - 1);
    for (int i = 0; i < cut; i++) send_byte(bytes[i], i == 0);
  endtask

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      seen.out_byte = out_ch.out_byte;
      seen.byte_role = f16fc_pkg::role_t'(out_ch.byte_role);
      seen.frame_done = out_ch.frame_done;
      seen.frame_ok = out_ch.frame_ok;
      seen.is_ack = out_ch.is_ack;
      seen.frame_id = out_ch.frame_id;
      seen.acked_id = out_ch.acked_id;
      seen.payload_len = out_ch.payload_len;
      book.check_echo(seen);
    end
  end

  // Receiver: short random stalls, one long hold-off that backs up the input side.
  initial begin
    out_ch.ready = 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold = 1'b0;
      end else if (stalls_on && !calm && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int pick;
    logic [7:0] len;
    bit hold_done;
    frame_flaw_t flaw;
    hold_done = 1'b0;
    book = new();
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.frame_start = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Bytes before any frame, then zero length, zero frame id, a restart mid-frame and bad check bytes.
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_frame(8'hFF, 8'h00, 8'd0, CLEAN);
    send_frame(8'h00, 8'h01, 8'd1, CLEAN);
    send_byte(8'h05, 1'b1);
    send_byte(8'h07, 1'b0);
    send_frame(8'h01, 8'hFF, 8'd2, BAD_SUM2);
    send_byte(8'hA5, 1'b0);
    send_frame(8'h80, 8'h00, 8'd0, BAD_SUM1);

    while (bytes_sent < ITEM_GOAL) begin
      if (bytes_sent >= CALM_FROM) calm = 1'b1;
      if (!hold_done && bytes_sent >= 500) begin
        long_hold = 1'b1;
        hold_done = 1'b1;
      end
      if ($urandom_range(0, 7) == 0) begin
        gaps_on = $urandom_range(0, 1);
        stalls_on = $urandom_range(0, 1);
      end
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
      end else begin
        pick = $urandom_range(0, 79);
        if (pick == 0) len = 8'($urandom_range(100, 255));
        else if (pick < 12) len = 8'd0;
        else len = 8'($urandom_range(1, 12));
        pick = $urandom_range(0, 99);
        if (pick < 65) flaw = CLEAN;
        else if (pick < 75) flaw = BAD_SUM1;
        else if (pick < 85) flaw = BAD_SUM2;
        else flaw = CUT_SHORT;
        send_frame(($urandom_range(0, 7) == 0) ? 8'h00 : 8'($urandom),
                   $urandom_range(0, 1) ? 8'h00 : 8'($urandom), len, flaw);
      end
    end

    in_ch.valid <= 1'b0;
    while (book.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (book.mismatches == 0 && book.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+design
design/f16fc_pkg.sv
design/f16fc_in_if.sv
design/f16fc_out_if.sv
design/f16fc_parse.sv
design/fletcher16_frame_checker.sv
tb/tb_fletcher16_frame_checker.sv
